// ----- rtl/closed_catmull_rom_curve_assert.svh -----
// Assertion macros for the Catmull-Rom curve block.
// They expect clk_i and rst_ni in the scope of use.
`ifndef CLOSED_CATMULL_ROM_CURVE_ASSERT_SVH
`define CLOSED_CATMULL_ROM_CURVE_ASSERT_SVH

// Same-cycle implication.
`define CCR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CCR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/ccr_pkg.sv -----
package ccr_pkg;

  // input word kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_EVAL  = 1'b1;

  // configuration register indexes
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 17;
  localparam logic [CFG_IDX_BITS-1:0] REG_POINT_COUNT = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SAMPLES     = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_U_STEP      = 2'd2;

  localparam int INDEX_BITS   = 6;
  localparam int COUNT_BITS   = 7;
  localparam int SAMPLES_BITS = 6;
  localparam int U_BITS       = 17;   // Q0.16 including 1.0

  localparam logic [COUNT_BITS-1:0]   COUNT_RST   = 7'd8;
  localparam logic [SAMPLES_BITS-1:0] SAMPLES_RST = 6'd10;
  localparam logic [U_BITS-1:0]       STEP_RST    = 17'd6554;
  localparam logic [U_BITS-1:0]       U_ONE       = 17'h10000;
  localparam int MIN_POINTS = 3;

  // blend arithmetic
  localparam int U2_BITS = 33;        // u^2 <= 2^32
  localparam int U3_BITS = 49;        // u^3 <= 2^48
  localparam int A_BITS  = 53;        // twice a weight, Q0.48, signed
  localparam int W_SHIFT = 33;        // Q0.48 doubled -> Q0.16
  localparam int W_BITS  = 18;        // weight, signed Q0.16, about -4855..65536
  localparam int OUT_SHIFT = 16;

  // point fetch: four reads; the last data is taken at count RD_LAST
  localparam int RD_CNT_BITS = 3;
  localparam logic [RD_CNT_BITS-1:0] RD_LAST = 3'd4;
  localparam int NUM_TAPS = 4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_RUN
  } state_e;

  typedef struct packed {
    logic vld;
    logic knot;
    logic last;
  } tag_t;

endpackage

// ----- rtl/ccr_in_if.sv -----
interface ccr_in_if #(
  parameter int COORD_BITS = 20
);
  logic                                valid;
  logic                                ready;
  logic                                kind;
  logic [ccr_pkg::INDEX_BITS-1:0]      point_index;
  logic signed [COORD_BITS-1:0]        coord_x;
  logic signed [COORD_BITS-1:0]        coord_y;
  logic signed [COORD_BITS-1:0]        coord_z;

  modport source (
    output valid, kind, point_index, coord_x, coord_y, coord_z,
    input  ready
  );

  modport sink (
    input  valid, kind, point_index, coord_x, coord_y, coord_z,
    output ready
  );
endinterface

// ----- rtl/ccr_out_if.sv -----
interface ccr_out_if #(
  parameter int COORD_BITS = 20
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] out_x;
  logic signed [COORD_BITS-1:0] out_y;
  logic signed [COORD_BITS-1:0] out_z;
  logic                         is_knot;
  logic                         last_of_run;

  modport source (
    output valid, out_x, out_y, out_z, is_knot, last_of_run,
    input  ready
  );

  modport sink (
    input  valid, out_x, out_y, out_z, is_knot, last_of_run,
    output ready
  );
endinterface

// ----- rtl/ccr_ram.sv -----
module ccr_ram #(
  parameter int WIDTH = 60,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/ccr_blend.sv -----
// Seven-stage blend pipe: u^2, u^3, weights, products, pair sums, round+saturate.
// The last stage is the output register. Everything advances on en_i.
module ccr_blend #(
  parameter int COORD_BITS = 20
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  ccr_pkg::tag_t                  tag_i,
  input  logic [ccr_pkg::U_BITS-1:0]     u_i,
  input  logic signed [COORD_BITS-1:0]   pts_i [ccr_pkg::NUM_TAPS][3],
  output ccr_pkg::tag_t                  tag_o,
  output logic signed [COORD_BITS-1:0]   crd_o [3],
  output logic                           busy_o
);

  localparam int UB  = ccr_pkg::U_BITS;
  localparam int U2B = ccr_pkg::U2_BITS;
  localparam int U3B = ccr_pkg::U3_BITS;
  localparam int AB  = ccr_pkg::A_BITS;
  localparam int WB  = ccr_pkg::W_BITS;
  localparam int WS  = ccr_pkg::W_SHIFT;
  localparam int NT  = ccr_pkg::NUM_TAPS;
  localparam int PB  = WB + COORD_BITS;
  localparam int SB  = PB + 2;
  localparam int NSTG = 7;

  localparam logic signed [AB-1:0] W_RND   = AB'(64'd1 << (WS - 1));
  localparam logic signed [AB-1:0] A1_BIAS = AB'(64'd1 << 49);
  localparam logic signed [SB-1:0] O_RND   = SB'(64'd1 << (ccr_pkg::OUT_SHIFT - 1));
  localparam logic signed [SB-1:0] SAT_HI  =
    {{(SB-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [SB-1:0] SAT_LO  =
    {{(SB-COORD_BITS+1){1'b1}}, {(COORD_BITS-1){1'b0}}};

  ccr_pkg::tag_t tag_q [NSTG];

  logic [UB-1:0]  u0_q, u1_q, u2_q;
  logic [U2B-1:0] sq1_q, sq2_q;
  logic [U3B-1:0] cu2_q;
  logic signed [WB-1:0] w3_q [NT];
  logic signed [PB-1:0] prod4_q [NT][3];
  logic signed [SB-1:0] pair5_q [2][3];
  logic signed [COORD_BITS-1:0] crd6_q [3];

  logic [2*UB-1:0]     sq;
  logic [U2B+UB-1:0]   cu;
  logic signed [AB-1:0] c3, c2, c1;
  logic signed [AB-1:0] a_d [NT];
  logic signed [AB-1:0] ar [NT];
  logic signed [WB-1:0] w_d [NT];
  logic signed [SB-1:0] tot [3];
  logic signed [SB-1:0] sh [3];
  logic signed [COORD_BITS-1:0] crd_d [3];

  assign sq = u0_q * u0_q;
  assign cu = sq1_q * u1_q;

  // twice the Catmull-Rom weights in Q0.48
  always_comb begin
    c3 = $signed({{(AB-U3B){1'b0}}, cu2_q});
    c2 = $signed({{(AB-U2B){1'b0}}, sq2_q}) <<< 16;
    c1 = $signed({{(AB-UB){1'b0}}, u2_q}) <<< 32;
    a_d[0] = -c3 + (c2 <<< 1) - c1;
    a_d[1] = (c3 <<< 1) + c3 - (c2 <<< 2) - c2 + A1_BIAS;
    a_d[2] = -((c3 <<< 1) + c3) + (c2 <<< 2) + c1;
    a_d[3] = c3 - c2;
    for (int i = 0; i < NT; i++) begin
      ar[i]  = a_d[i] + W_RND;
      w_d[i] = ar[i][WS+WB-1:WS];
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      tot[j] = pair5_q[0][j] + pair5_q[1][j] + O_RND;
      sh[j]  = tot[j] >>> ccr_pkg::OUT_SHIFT;
      if (sh[j] > SAT_HI) begin
        crd_d[j] = SAT_HI[COORD_BITS-1:0];
      end else if (sh[j] < SAT_LO) begin
        crd_d[j] = SAT_LO[COORD_BITS-1:0];
      end else begin
        crd_d[j] = sh[j][COORD_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NSTG; s++) begin
        tag_q[s] <= '0;
      end
    end else if (en_i) begin
      tag_q[0] <= tag_i;
      for (int s = 1; s < NSTG; s++) begin
        tag_q[s] <= tag_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      u0_q  <= u_i;
      u1_q  <= u0_q;
      sq1_q <= sq[U2B-1:0];
      u2_q  <= u1_q;
      sq2_q <= sq1_q;
      cu2_q <= cu[U3B-1:0];
      for (int i = 0; i < NT; i++) begin
        w3_q[i] <= w_d[i];
        for (int j = 0; j < 3; j++) begin
          prod4_q[i][j] <= PB'(w3_q[i]) * PB'(pts_i[i][j]);
        end
      end
      for (int j = 0; j < 3; j++) begin
        pair5_q[0][j] <= SB'(prod4_q[0][j]) + SB'(prod4_q[1][j]);
        pair5_q[1][j] <= SB'(prod4_q[2][j]) + SB'(prod4_q[3][j]);
        crd6_q[j]     <= crd_d[j];
      end
    end
  end

  assign busy_o = tag_q[0].vld | tag_q[1].vld | tag_q[2].vld |
                  tag_q[3].vld | tag_q[4].vld | tag_q[5].vld;
  assign tag_o  = tag_q[NSTG-1];
  assign crd_o  = crd6_q;

endmodule

// ----- rtl/closed_catmull_rom_curve.sv -----
// Closed uniform Catmull-Rom curve tessellator. Control points live in a
// one-port-write, one-port-read RAM of MAX_POINTS entries (x, y, z packed).
// A write word (kind 0) stores one point and gives nothing back. An evaluate
// word (kind 1) for segment i fetches points i-1, i, i+1, i+2 (wrapping on the
// ring of point_count points), then issues one word per cycle while the output
// is not stalled: the knot (point i itself) followed by S curve samples, the
// last one at u = 1. Samples travel through a seven-stage blend pipe whose last
// stage is the output register. An evaluate word therefore occupies the block
// through the fetch, the issue of S + 1 words and the pipe drain, plus any
// output stalls; a write leaves the input open. The input is held off until
// the stages before the output register are empty, so point registers and the
// RAM never see a fetch overlap a store. Entries never written read as junk.
// Configuration writes are taken any time but belong in idle periods.
module closed_catmull_rom_curve #(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 20
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  ccr_in_if.sink                                in_i,
  ccr_out_if.source                             out_o,
  input  logic                                  cfg_we_i,
  input  logic [ccr_pkg::CFG_IDX_BITS-1:0]      cfg_idx_i,
  input  logic [ccr_pkg::CFG_DATA_BITS-1:0]     cfg_data_i
);

  localparam int AW = $clog2(MAX_POINTS);      // RAM address
  localparam int NW = $clog2(MAX_POINTS + 1);  // ring size and ring index
  localparam int PW = 3 * COORD_BITS;          // one stored point
  localparam int NT = ccr_pkg::NUM_TAPS;
  localparam int UB = ccr_pkg::U_BITS;

  // configuration
  logic [ccr_pkg::COUNT_BITS-1:0]   cnt_q;
  logic [ccr_pkg::SAMPLES_BITS-1:0] smp_q;
  logic [UB-1:0]                    step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= ccr_pkg::COUNT_RST;
      smp_q  <= ccr_pkg::SAMPLES_RST;
      step_q <= ccr_pkg::STEP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ccr_pkg::REG_POINT_COUNT: cnt_q  <= cfg_data_i[ccr_pkg::COUNT_BITS-1:0];
        ccr_pkg::REG_SAMPLES:     smp_q  <= cfg_data_i[ccr_pkg::SAMPLES_BITS-1:0];
        ccr_pkg::REG_U_STEP:      step_q <= cfg_data_i[UB-1:0];
        default: ;  // unknown index: dropped
      endcase
    end
  end

  // effective ring size, clamped to 3..MAX_POINTS; zero samples acts as one
  logic [NW-1:0] n_eff;
  logic [ccr_pkg::SAMPLES_BITS-1:0] s_eff;

  always_comb begin
    if (int'(cnt_q) < ccr_pkg::MIN_POINTS) begin
      n_eff = NW'(ccr_pkg::MIN_POINTS);
    end else if (int'(cnt_q) > MAX_POINTS) begin
      n_eff = NW'(MAX_POINTS);
    end else begin
      n_eff = NW'(cnt_q);
    end
  end

  assign s_eff = (smp_q == '0) ? ccr_pkg::SAMPLES_BITS'(1) : smp_q;

  // control
  ccr_pkg::state_e state_q, state_d;
  logic [ccr_pkg::RD_CNT_BITS-1:0]  rd_cnt_q, rd_cnt_d;
  logic [ccr_pkg::SAMPLES_BITS-1:0] k_q, k_d;
  logic [UB-1:0]                    uacc_q, uacc_d;

  logic busy, en, in_rdy, in_fire, wr_go, eval_go;
  ccr_pkg::tag_t tag_out, issue_tag;
  logic [UB-1:0] issue_u, u_next;
  logic [UB:0]   u_sum;

  assign in_rdy  = (state_q == ccr_pkg::ST_IDLE) && !busy;
  assign in_fire = in_i.valid && in_rdy;
  assign wr_go   = in_fire && (in_i.kind == ccr_pkg::KIND_WRITE) &&
                   (int'(in_i.point_index) < MAX_POINTS);
  // a segment start outside the ring gives no words
  assign eval_go = in_fire && (in_i.kind == ccr_pkg::KIND_EVAL) &&
                   (int'(in_i.point_index) < int'(n_eff));

  // whole pipe stalls when the output register is full and not taken
  assign en = !tag_out.vld || out_o.ready;

  // u = min(k * step, 1.0), built by a saturating accumulator
  assign u_sum  = {1'b0, uacc_q} + {1'b0, step_q};
  assign u_next = (u_sum > {1'b0, ccr_pkg::U_ONE}) ? ccr_pkg::U_ONE : u_sum[UB-1:0];

  // tap addresses, worked out when the evaluate word is taken
  logic [NW-1:0] idxn, prv, nxt, pst;
  logic [NW-1:0] tap_q [NT];

  always_comb begin
    idxn = NW'(in_i.point_index);
    prv  = (idxn == '0) ? NW'(n_eff - NW'(1)) : NW'(idxn - NW'(1));
    nxt  = (NW'(idxn + NW'(1)) == n_eff) ? '0 : NW'(idxn + NW'(1));
    pst  = (NW'(nxt + NW'(1)) == n_eff) ? '0 : NW'(nxt + NW'(1));
  end

  always_ff @(posedge clk_i) begin
    if (eval_go) begin
      tap_q[0] <= prv;
      tap_q[1] <= idxn;
      tap_q[2] <= nxt;
      tap_q[3] <= pst;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ccr_pkg::ST_IDLE;
      rd_cnt_q <= '0;
      k_q      <= '0;
      uacc_q   <= '0;
    end else begin
      state_q  <= state_d;
      rd_cnt_q <= rd_cnt_d;
      k_q      <= k_d;
      uacc_q   <= uacc_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    rd_cnt_d  = rd_cnt_q;
    k_d       = k_q;
    uacc_d    = uacc_q;
    issue_tag = '0;
    issue_u   = '0;
    unique case (state_q)
      ccr_pkg::ST_IDLE: begin
        if (eval_go) begin
          state_d  = ccr_pkg::ST_READ;
          rd_cnt_d = '0;
        end
      end
      ccr_pkg::ST_READ: begin
        rd_cnt_d = ccr_pkg::RD_CNT_BITS'(rd_cnt_q + 1'b1);
        if (rd_cnt_q == ccr_pkg::RD_LAST) begin
          state_d = ccr_pkg::ST_RUN;
          k_d     = '0;
          uacc_d  = '0;
        end
      end
      ccr_pkg::ST_RUN: begin
        issue_tag.vld = 1'b1;
        if (k_q == '0) begin
          // knot: u = 0 makes the blend return point i exactly
          issue_tag.knot = 1'b1;
        end else if (k_q == s_eff) begin
          issue_tag.last = 1'b1;
          issue_u        = ccr_pkg::U_ONE;
        end else begin
          issue_u = u_next;
        end
        if (en) begin
          k_d = ccr_pkg::SAMPLES_BITS'(k_q + 1'b1);
          if (k_q != '0) begin
            uacc_d = u_next;
          end
          if (k_q == s_eff) begin
            state_d = ccr_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = ccr_pkg::ST_IDLE;
    endcase
  end

  // point store
  logic [PW-1:0] rdata;
  logic [AW-1:0] raddr;

  assign raddr = AW'(tap_q[rd_cnt_q[1:0]]);

  ccr_ram #(
    .WIDTH (PW),
    .DEPTH (MAX_POINTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr_go),
    .waddr_i (AW'(in_i.point_index)),
    .wdata_i ({in_i.coord_x, in_i.coord_y, in_i.coord_z}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // fetched taps; data for read r lands in the cycle after its address
  logic signed [COORD_BITS-1:0] pts_q [NT][3];
  logic [1:0] cap_idx;

  assign cap_idx = 2'(rd_cnt_q - 1'b1);

  always_ff @(posedge clk_i) begin
    if (state_q == ccr_pkg::ST_READ && rd_cnt_q != '0) begin
      pts_q[cap_idx][0] <= $signed(rdata[PW-1 -: COORD_BITS]);
      pts_q[cap_idx][1] <= $signed(rdata[2*COORD_BITS-1 -: COORD_BITS]);
      pts_q[cap_idx][2] <= $signed(rdata[COORD_BITS-1:0]);
    end
  end

  logic signed [COORD_BITS-1:0] crd [3];

  ccr_blend #(
    .COORD_BITS (COORD_BITS)
  ) u_blend (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .tag_i  (issue_tag),
    .u_i    (issue_u),
    .pts_i  (pts_q),
    .tag_o  (tag_out),
    .crd_o  (crd),
    .busy_o (busy)
  );

  assign in_i.ready        = in_rdy;
  assign out_o.valid       = tag_out.vld;
  assign out_o.out_x       = crd[0];
  assign out_o.out_y       = crd[1];
  assign out_o.out_z       = crd[2];
  assign out_o.is_knot     = tag_out.knot;
  assign out_o.last_of_run = tag_out.last;

endmodule

// ----- rtl/ccr_checker.sv -----
`include "closed_catmull_rom_curve_assert.svh"

module ccr_checker #(
  parameter int COORD_BITS = 20
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic                         in_kind_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic signed [COORD_BITS-1:0] out_x_i,
  input logic signed [COORD_BITS-1:0] out_y_i,
  input logic signed [COORD_BITS-1:0] out_z_i,
  input logic                         out_is_knot_i,
  input logic                         out_last_i
);

  // a stalled result word holds
  `CCR_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i,
    out_valid_i && $stable(out_x_i) && $stable(out_y_i) && $stable(out_z_i) &&
    $stable(out_is_knot_i) && $stable(out_last_i), "result word changed under stall")

  // storing a point never blocks the next word
  `CCR_ASSERT_NEXT(a_write_free,
    in_valid_i && in_ready_i && (in_kind_i == ccr_pkg::KIND_WRITE),
    in_ready_i, "input blocked after a point write")

  // a knot always has samples behind it, so input must be held off
  `CCR_ASSERT_NOW(a_knot_busy, out_valid_i && out_is_knot_i,
    !in_ready_i, "input open while a segment is in flight")

  // after the last sample the next word can only open a new segment
  `CCR_ASSERT_NEXT(a_run_order, out_valid_i && out_ready_i && out_last_i,
    !out_valid_i || out_is_knot_i, "sample after the end of a segment")

endmodule

bind closed_catmull_rom_curve ccr_checker #(
  .COORD_BITS (COORD_BITS)
) u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .in_kind_i     (in_i.kind),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_x_i       (out_o.out_x),
  .out_y_i       (out_o.out_y),
  .out_z_i       (out_o.out_z),
  .out_is_knot_i (out_o.is_knot),
  .out_last_i    (out_o.last_of_run)
);

// ----- tb/closed_catmull_rom_curve_tb.sv -----
`timescale 1ns / 1ps

module closed_catmull_rom_curve_tb;

  localparam int MAX_POINTS = 64;
  localparam int COORD_BITS = 20;

  // the one register index that decodes to nothing
  localparam logic [ccr_pkg::CFG_IDX_BITS-1:0] REG_SPARE = 2'd3;

  localparam logic signed [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  // fixed point scale factors of the blend (u is Q0.16, twice a weight Q0.48)
  localparam longint U_SCALE = 64'sd65536;
  localparam longint P32     = 64'sd4294967296;
  localparam longint P48     = 64'sd281474976710656;

  localparam int SETTLE_CYCLES = 40;   // longer than the fetch + pipe drain
  localparam int LONG_HOLD     = 400;  // output stall that backs up the input

  // one input word as queued for the driver
  typedef struct {
    logic                             kind;
    logic [ccr_pkg::INDEX_BITS-1:0]   idx;
    logic signed [COORD_BITS-1:0]     x;
    logic signed [COORD_BITS-1:0]     y;
    logic signed [COORD_BITS-1:0]     z;
    bit                               drain_first;  // hold until every curve word is back
  } point_cmd_t;

  // one curve word as the block should return it
  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
    logic                         knot;
    logic                         last;
  } curve_word_t;

  logic                              clk_i = 1'b0;
  logic                              rst_ni;
  logic                              cfg_we_i;
  logic [ccr_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i;
  logic [ccr_pkg::CFG_DATA_BITS-1:0] cfg_data_i;

  ccr_in_if  #(.COORD_BITS(COORD_BITS)) pt_in ();
  ccr_out_if #(.COORD_BITS(COORD_BITS)) curve_out ();

  closed_catmull_rom_curve #(
    .MAX_POINTS(MAX_POINTS),
    .COORD_BITS(COORD_BITS)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (pt_in),
    .out_o      (curve_out),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Shadow of the block: register copies and the control point ring as the
  // block holds it once every accepted word has taken effect.
  // ---------------------------------------------------------------------------
  logic [ccr_pkg::COUNT_BITS-1:0]   cfg_points  = ccr_pkg::COUNT_RST;
  logic [ccr_pkg::SAMPLES_BITS-1:0] cfg_samples = ccr_pkg::SAMPLES_RST;
  logic [ccr_pkg::U_BITS-1:0]       cfg_step    = ccr_pkg::STEP_RST;
  longint                           ring_pts [MAX_POINTS][3];

  // which entries the stimulus has written so far; evaluates never touch
  // an entry outside this set
  bit gen_written [MAX_POINTS];

  point_cmd_t  word_queue [$];   // words waiting for the driver
  curve_word_t curve_expect [$]; // curve words still owed by the block

  int  fail_count = 0;
  bit  calm = 1'b0;              // no idling on either side at the end
  bit  next_drain = 1'b0;
  int  hold_asked = 0;           // long output stalls requested ...
  int  hold_done;                // ... and started
  int  hold_left;
  int  send_gap;
  int  rdy_gap;
  bit  bus_full;
  point_cmd_t on_bus;

  // ring size after clamping to 3..MAX_POINTS
  function automatic int ring_size();
    int n;
    n = cfg_points;
    if (n < ccr_pkg::MIN_POINTS) n = ccr_pkg::MIN_POINTS;
    if (n > MAX_POINTS) n = MAX_POINTS;
    return n;
  endfunction

  // one curve sample: Catmull-Rom weights at u, blended over four points
  function automatic curve_word_t curve_sample(longint u, int ia, int ib, int ic, int id,
                                               bit last);
    longint      u2, u3, acc, v;
    longint      a [4];
    longint      w [4];
    longint      c [3];
    curve_word_t r;
    u2 = u * u;
    u3 = u2 * u;
    a[0] = -u3 + 2 * u2 * U_SCALE - u * P32;
    a[1] = 3 * u3 - 5 * u2 * U_SCALE + 2 * P48;
    a[2] = -3 * u3 + 4 * u2 * U_SCALE + u * P32;
    a[3] = u3 - u2 * U_SCALE;
    // halve and round half up to Q0.16
    for (int i = 0; i < 4; i++) w[i] = (a[i] + P32) >>> 33;
    for (int j = 0; j < 3; j++) begin
      acc = w[0] * ring_pts[ia][j] + w[1] * ring_pts[ib][j]
          + w[2] * ring_pts[ic][j] + w[3] * ring_pts[id][j];
      v = (acc + 64'sd32768) >>> 16;
      if (v > longint'(C_MAX)) v = longint'(C_MAX);
      if (v < longint'(C_MIN)) v = longint'(C_MIN);
      c[j] = v;
    end
    r.x    = c[0][COORD_BITS-1:0];
    r.y    = c[1][COORD_BITS-1:0];
    r.z    = c[2][COORD_BITS-1:0];
    r.knot = 1'b0;
    r.last = last;
    return r;
  endfunction

  // expected words of one segment: the knot, then S samples
  function automatic void tessellate_segment(int idx);
    int          n, s, prev, nxt, post;
    longint      u;
    curve_word_t kw;
    n = ring_size();
    if (idx >= n) return;     // segment off the ring: nothing comes back
    s = (cfg_samples == 0) ? 1 : cfg_samples;
    prev = (idx == 0) ? n - 1 : idx - 1;
    nxt  = (idx + 1 == n) ? 0 : idx + 1;
    post = (nxt + 1 == n) ? 0 : nxt + 1;
    kw.x    = ring_pts[idx][0][COORD_BITS-1:0];
    kw.y    = ring_pts[idx][1][COORD_BITS-1:0];
    kw.z    = ring_pts[idx][2][COORD_BITS-1:0];
    kw.knot = 1'b1;
    kw.last = 1'b0;
    curve_expect.insert(curve_expect.size(), kw);
    for (int k = 1; k <= s; k++) begin
      u = longint'(k) * longint'(cfg_step);
      if (u > U_SCALE || k == s) u = U_SCALE;   // last sample pinned to u = 1
      curve_expect.insert(curve_expect.size(),
                          curve_sample(u, prev, idx, nxt, post, k == s));
    end
  endfunction

  // effect of one accepted word on the shadow
  function automatic void apply_word(point_cmd_t c);
    if (c.kind == ccr_pkg::KIND_WRITE) begin
      ring_pts[c.idx][0] = longint'(c.x);
      ring_pts[c.idx][1] = longint'(c.y);
      ring_pts[c.idx][2] = longint'(c.z);
    end else begin
      tessellate_segment(c.idx);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic signed [COORD_BITS-1:0] rand_coord();
    case ($urandom_range(0, 7))
      0:       return C_MAX;
      1:       return C_MIN;
      default: return COORD_BITS'($urandom());
    endcase
  endfunction

  function automatic void push_word(point_cmd_t c);
    c.drain_first = next_drain;
    next_drain = 1'b0;
    word_queue.insert(word_queue.size(), c);
  endfunction

  function automatic void push_write(int idx, logic signed [COORD_BITS-1:0] x,
                                     logic signed [COORD_BITS-1:0] y,
                                     logic signed [COORD_BITS-1:0] z);
    point_cmd_t c;
    c.kind = ccr_pkg::KIND_WRITE;
    c.idx  = ccr_pkg::INDEX_BITS'(idx);
    c.x    = x;
    c.y    = y;
    c.z    = z;
    gen_written[idx] = 1'b1;
    push_word(c);
  endfunction

  // evaluate segment idx; any neighbor not yet written gets a random point first
  function automatic void push_eval(int idx);
    int         n;
    int         nb [4];
    point_cmd_t c;
    n = ring_size();
    if (idx < n) begin
      nb[0] = (idx == 0) ? n - 1 : idx - 1;
      nb[1] = idx;
      nb[2] = (idx + 1 == n) ? 0 : idx + 1;
      nb[3] = (nb[2] + 1 == n) ? 0 : nb[2] + 1;
      foreach (nb[i])
        if (!gen_written[nb[i]]) push_write(nb[i], rand_coord(), rand_coord(), rand_coord());
    end
    c.kind = ccr_pkg::KIND_EVAL;
    c.idx  = ccr_pkg::INDEX_BITS'(idx);
    c.x    = COORD_BITS'($urandom());   // ignored by the block
    c.y    = COORD_BITS'($urandom());
    c.z    = COORD_BITS'($urandom());
    push_word(c);
  endfunction

  // mostly in-ring segments, some writes, a few segments off the ring
  function automatic void push_random_word();
    int n;
    n = ring_size();
    case ($urandom_range(0, 9))
      0, 1: begin
        if ($urandom_range(0, 1) != 0)
          push_write($urandom_range(0, n - 1), rand_coord(), rand_coord(), rand_coord());
        else
          push_write($urandom_range(0, MAX_POINTS - 1), rand_coord(), rand_coord(),
                     rand_coord());
      end
      2: begin
        if (n < MAX_POINTS) push_eval($urandom_range(n, MAX_POINTS - 1));
        else push_eval($urandom_range(0, n - 1));
      end
      default: push_eval($urandom_range(0, n - 1));
    endcase
  endfunction

  // register write; only called while the block is idle
  task automatic write_reg(logic [ccr_pkg::CFG_IDX_BITS-1:0] idx,
                           logic [ccr_pkg::CFG_DATA_BITS-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      ccr_pkg::REG_POINT_COUNT: cfg_points  = data[ccr_pkg::COUNT_BITS-1:0];
      ccr_pkg::REG_SAMPLES:     cfg_samples = data[ccr_pkg::SAMPLES_BITS-1:0];
      ccr_pkg::REG_U_STEP:      cfg_step    = data[ccr_pkg::U_BITS-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // everything sent, everything back, and the block given time to go quiet
  task automatic drain();
    wait (word_queue.size() == 0 && !bus_full);
    wait (curve_expect.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_phase(logic [ccr_pkg::CFG_DATA_BITS-1:0] cnt_w,
                           logic [ccr_pkg::CFG_DATA_BITS-1:0] samp_w,
                           logic [ccr_pkg::CFG_DATA_BITS-1:0] step_w,
                           int n_words, bit long_hold);
    write_reg(ccr_pkg::REG_POINT_COUNT, cnt_w);
    write_reg(ccr_pkg::REG_SAMPLES, samp_w);
    write_reg(ccr_pkg::REG_U_STEP, step_w);
    @(negedge clk_i);
    for (int i = 0; i < n_words; i++) begin
      // one word in the middle waits for the output side to empty
      if (i == n_words / 2) next_drain = 1'b1;
      push_random_word();
    end
    if (long_hold) hold_asked <= hold_asked + 1;
    drain();
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers queued words, idles in bursts, feeds accepted words to
  // the shadow at the edge where they are taken.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pt_in.valid       <= 1'b0;
      pt_in.kind        <= ccr_pkg::KIND_WRITE;
      pt_in.point_index <= '0;
      pt_in.coord_x     <= '0;
      pt_in.coord_y     <= '0;
      pt_in.coord_z     <= '0;
      bus_full = 1'b0;
      send_gap = 0;
    end else begin
      if (pt_in.valid && pt_in.ready) begin
        apply_word(on_bus);
        bus_full = 1'b0;
      end
      if (!bus_full) begin
        if (send_gap != 0) begin
          send_gap--;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(0, 12);
        end else if (word_queue.size() != 0 &&
                     !(word_queue[0].drain_first && curve_expect.size() != 0)) begin
          on_bus   = word_queue.pop_front();
          bus_full = 1'b1;
          pt_in.kind        <= on_bus.kind;
          pt_in.point_index <= on_bus.idx;
          pt_in.coord_x     <= on_bus.x;
          pt_in.coord_y     <= on_bus.y;
          pt_in.coord_z     <= on_bus.z;
        end
      end
      pt_in.valid <= bus_full;
    end
  end

  // Long output stall: counted here so the monitor only has to look at it.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_done != hold_asked) begin
      hold_left <= LONG_HOLD;
      hold_done <= hold_done + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each taken curve word against the oldest expectation and
  // throttles ready in random bursts.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    curve_word_t want;
    logic        rdy;
    if (!rst_ni) begin
      curve_out.ready <= 1'b0;
      rdy_gap = 0;
    end else begin
      if (curve_out.valid && curve_out.ready) begin
        if (curve_expect.size() == 0) begin
          $error("curve word with nothing expected: x %0d y %0d z %0d",
                 curve_out.out_x, curve_out.out_y, curve_out.out_z);
          fail_count++;
        end else begin
          want = curve_expect.pop_front();
          if (curve_out.out_x !== want.x) begin
            $error("out_x: expected %0d, got %0d", want.x, curve_out.out_x);
            fail_count++;
          end
          if (curve_out.out_y !== want.y) begin
            $error("out_y: expected %0d, got %0d", want.y, curve_out.out_y);
            fail_count++;
          end
          if (curve_out.out_z !== want.z) begin
            $error("out_z: expected %0d, got %0d", want.z, curve_out.out_z);
            fail_count++;
          end
          if (curve_out.is_knot !== want.knot) begin
            $error("is_knot: expected %0d, got %0d", want.knot, curve_out.is_knot);
            fail_count++;
          end
          if (curve_out.last_of_run !== want.last) begin
            $error("last_of_run: expected %0d, got %0d", want.last, curve_out.last_of_run);
            fail_count++;
          end
        end
      end
      if (hold_left != 0) begin
        rdy = 1'b0;
      end else if (rdy_gap != 0) begin
        rdy_gap--;
        rdy = 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        rdy_gap = $urandom_range(0, 12);
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      curve_out.ready <= rdy;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: directed words at reset settings, then random phases that walk
  // the registers through their extremes, then a final phase with no idling.
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = ccr_pkg::REG_POINT_COUNT;
    cfg_data_i = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // ring of 8 at reset; extremes side by side drive the curve into saturation
    push_write(0, C_MAX, C_MIN, '0);
    push_write(1, C_MIN, C_MAX, -20'sd1);
    push_write(2, C_MAX, C_MAX, C_MAX);
    push_write(3, C_MIN, C_MIN, C_MIN);
    push_write(4, '0, 20'sd1, -20'sd1);
    push_write(5, 20'sd1, -20'sd1, 20'sh12345);
    push_write(6, C_MAX, '0, C_MIN);
    push_write(7, C_MIN, '0, C_MAX);
    push_eval(0);                 // previous point wraps to the top of the ring
    push_eval(7);                 // next point wraps to 0
    push_eval(6);                 // the point after next wraps
    push_eval(2);
    push_eval(8);                 // just off the ring
    push_eval(63);                // far off the ring, index all ones
    push_write(63, C_MAX, C_MIN, C_MAX);
    push_eval(4);
    push_write(3, 20'sh00400, -20'sh00800, 20'sh7F000);
    push_eval(3);
    push_eval(1);
    drain();

    // tiny ring (count with junk high bits truncates to 3), one full-step sample
    run_phase(17'h0FF03, 17'd1, 17'd65536, 30, 1'b0);
    // full ring, most samples; the output stalls long enough to back up the input
    run_phase(17'd64, 17'd63, 17'd1040, 40, 1'b1);
    // count above the store clamps, zero samples act as one, zero step
    run_phase(17'd127, 17'd0, 17'd0, 25, 1'b0);
    // step so large that u saturates; a write to the spare index does nothing
    write_reg(REG_SPARE, 17'h1ABCD);
    run_phase(17'd5, 17'd4, 17'h1FFFF, 40, 1'b0);
    run_phase(17'd0, 17'd7, 17'd9362, 60, 1'b0);
    for (int p = 0; p < 3; p++) begin
      int s;
      s = $urandom_range(1, 16);
      run_phase(ccr_pkg::CFG_DATA_BITS'($urandom_range(3, 64)),
                ccr_pkg::CFG_DATA_BITS'(s),
                ccr_pkg::CFG_DATA_BITS'(($urandom_range(0, 3) == 0) ?
                                        $urandom_range(1, 65536) : 65536 / s),
                40, 1'b0);
    end
    calm = 1'b1;
    run_phase(17'd12, 17'd6, 17'd10923, 45, 1'b0);

    if (fail_count == 0) begin
      $display("closed_catmull_rom_curve_tb OK");
    end else begin
      $display("closed_catmull_rom_curve_tb NOT OK");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #50_000_000;
    $display("closed_catmull_rom_curve_tb NOT OK");
    $finish;
  end

endmodule
